// ----- rtl/mouse_power_curve_accel_macros.svh -----
// Assertion macros for the pointer acceleration block.
// Each macro names its label, clock, active-low reset and the checked terms.
`ifndef MOUSE_POWER_CURVE_ACCEL_MACROS_SVH
`define MOUSE_POWER_CURVE_ACCEL_MACROS_SVH
`ifndef SYNTHESIS
`define MPCA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pointer acceleration assertion failed");
`define MPCA_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
    else $error("pointer acceleration latency assertion failed");
`else
`define MPCA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MPCA_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons)
`endif
`endif

// ----- rtl/mpca_pkg.sv -----
`default_nettype none

package mpca_pkg;

  // Register map, one 32-bit word per register.
  typedef enum logic [1:0] {
    REG_ACCEL_FACTOR    = 2'd0,
    REG_CURVE_POWER     = 2'd1,
    REG_SPEED_THRESHOLD = 2'd2,
    REG_ACCEL_ENABLE    = 2'd3
  } cfg_reg_e;

  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FACTOR_W = 9;
  localparam int unsigned POWER_W  = 10;
  localparam int unsigned THR_W    = 12;
  localparam int unsigned GAIN_W   = 10;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 9'd154;
  localparam logic [POWER_W-1:0]  POWER_RST  = 10'd512;
  localparam logic [THR_W-1:0]    THR_RST    = 12'd50;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 10'd256;
  localparam logic [GAIN_W-1:0] GAIN_MIN   = 10'd128;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 10'd768;

  // Radicand widths of the speed root and of the exp2 half-steps.
  localparam int unsigned SPD_RAD_W = 64;
  localparam int unsigned EXP_RAD_W = 62;
  localparam int unsigned LOG_STEPS = 16;

  // Sums of squares at or above this use the coarse speed form.
  localparam logic [63:0] BIG_SUM = 64'h0000_8000_0000_0000;
  // Speed excess at which the normalized speed saturates to 2^24 - 1.
  localparam logic [39:0] N_SAT_DIFF = 40'd6553600;
  // floor(x / 25) = (x * DIV25_MAGIC) >> 35 for every 32-bit x.
  localparam logic [30:0] DIV25_MAGIC = 31'h51EB851F;

endpackage

`default_nettype wire

// ----- rtl/mpca_sqrt_pipe.sv -----
`default_nettype none
`include "mouse_power_curve_accel_macros.svh"

// Floor square root, one result bit per register stage.
module mpca_sqrt_pipe #(
  parameter int unsigned RAD_W  = 64,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [RAD_W-1:0]      rad_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [RAD_W/2-1:0]    root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned TW     = RAD_W + 1;

  logic              vld_q  [ROOT_W];
  logic [RAD_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int unsigned J = ROOT_W - 1 - s;
    logic              vld_in;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic [TW-1:0]     trial;
    logic              fits;
    logic [RAD_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Setting bit J raises the square by 2*root*2^J + 2^(2J).
    always_comb begin
      trial  = (TW'(root_in) << (J + 1)) | (TW'(1) << (2 * J));
      fits   = {1'b0, rem_in} >= trial;
      rem_d  = fits ? RAD_W'({1'b0, rem_in} - trial) : rem_in;
      root_d = fits ? (root_in | (ROOT_W'(1) << J)) : root_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      root_q[s] <= root_d;
      side_q[s] <= side_in;
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

  `MPCA_ASSERT_DLY(a_sqrt_latency, clk_i, rst_ni, valid_i, ROOT_W, valid_o)
  `MPCA_ASSERT_IMP(a_sqrt_rem_bound, clk_i, rst_ni, valid_o, rem_q[ROOT_W-1] <= (RAD_W'(root_q[ROOT_W-1]) << 1))

endmodule

`default_nettype wire

// ----- rtl/mouse_power_curve_accel.sv -----
`default_nettype none
`include "mouse_power_curve_accel_macros.svh"

// Channel   | Handshake                         | Payload
// ----------+-----------------------------------+-----------------------------------------
// item in   | start, busy (busy is always low)  | delta_x_i, delta_y_i
// result    | result_valid_o, one-cycle strobe  | scaled_x_o, scaled_y_o, gain_used_o
// config    | APB: psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// An item is taken on every cycle in which start is high; busy never rises.
// Most pipeline stages lie in the bit-serial square roots: one for the speed and sixteen
// chained half-step roots that build the fractional power of two.
// Reset clears every valid bit and loads the register defaults; payload is not reset.
// The receiver cannot stall, so nothing ever holds the pipeline.
module mouse_power_curve_accel
  import mpca_pkg::*;
#(
  parameter int unsigned DELTA_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [DELTA_WIDTH-1:0] delta_x_i,
  input  logic signed [DELTA_WIDTH-1:0] delta_y_i,
  output logic                          result_valid_o,
  output logic signed [DELTA_WIDTH-1:0] scaled_x_o,
  output logic signed [DELTA_WIDTH-1:0] scaled_y_o,
  output logic [GAIN_W-1:0]             gain_used_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  localparam int unsigned DW         = DELTA_WIDTH;
  localparam int unsigned SPD_ROOT_W = SPD_RAD_W / 2;
  localparam int unsigned EXP_ROOT_W = EXP_RAD_W / 2;
  localparam int unsigned QW         = DW + 2;
  localparam int unsigned LAT        = 3 + SPD_ROOT_W + 3 + LOG_STEPS + 1
                                       + LOG_STEPS * EXP_ROOT_W + 4;

  // Item fields that ride along the middle of the pipeline.
  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 active;  // enabled and at or above the threshold
    logic                 nz;      // normalized speed is nonzero
  } item_t;

  typedef struct packed {
    item_t             item;
    logic signed [8:0] k;          // integer part of the exponent
    logic [15:0]       f;          // fractional part of the exponent
  } exp_side_t;

  localparam int unsigned EXP_SIDE_W = $bits(exp_side_t);

  // ---------------------------------------------------------------------------
  // Configuration registers. Words are selected by paddr[3:2]; the byte
  // offset bits are ignored. Stages read them directly; the user must make writes
  // only while no item is in flight, which the block does not enforce.
  // ---------------------------------------------------------------------------
  logic [FACTOR_W-1:0] accel_factor_q;
  logic [POWER_W-1:0]  curve_power_q;
  logic [THR_W-1:0]    speed_threshold_q;
  logic                accel_enable_q;
  cfg_reg_e            reg_sel;
  logic                cfg_we;

  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_factor_q    <= FACTOR_RST;
      curve_power_q     <= POWER_RST;
      speed_threshold_q <= THR_RST;
      accel_enable_q    <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_ACCEL_FACTOR:    accel_factor_q    <= pwdata[FACTOR_W-1:0];
        REG_CURVE_POWER:     curve_power_q     <= pwdata[POWER_W-1:0];
        REG_SPEED_THRESHOLD: speed_threshold_q <= pwdata[THR_W-1:0];
        REG_ACCEL_ENABLE:    accel_enable_q    <= pwdata[0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ACCEL_FACTOR:    prdata = DATA_W'(accel_factor_q);
      REG_CURVE_POWER:     prdata = DATA_W'(curve_power_q);
      REG_SPEED_THRESHOLD: prdata = DATA_W'(speed_threshold_q);
      REG_ACCEL_ENABLE:    prdata = DATA_W'(accel_enable_q);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stages 1-3: magnitudes, squares, and the radicand of the speed root.
  // Small sums are scaled by 2^16 so the root comes out in Q.8 directly.
  // ---------------------------------------------------------------------------
  logic                 s1_vld_q, s2_vld_q, s3_vld_q;
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s2_dx_q, s2_dy_q, s3_dx_q, s3_dy_q;
  logic [DW-1:0]        s1_ax_q, s1_ay_q;
  logic [2*DW-1:0]      s2_sqx_q, s2_sqy_q;
  logic [63:0]          s3_rad_q;
  logic                 s3_big_q;
  logic [63:0]          sum_w;

  assign sum_w = 64'(s2_sqx_q) + 64'(s2_sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q  <= delta_x_i;
    s1_dy_q  <= delta_y_i;
    s1_ax_q  <= delta_x_i[DW-1] ? DW'(-delta_x_i) : DW'(delta_x_i);
    s1_ay_q  <= delta_y_i[DW-1] ? DW'(-delta_y_i) : DW'(delta_y_i);
    s2_dx_q  <= s1_dx_q;
    s2_dy_q  <= s1_dy_q;
    s2_sqx_q <= s1_ax_q * s1_ax_q;
    s2_sqy_q <= s1_ay_q * s1_ay_q;
    s3_dx_q  <= s2_dx_q;
    s3_dy_q  <= s2_dy_q;
    s3_big_q <= sum_w >= BIG_SUM;
    s3_rad_q <= (sum_w >= BIG_SUM) ? sum_w : (sum_w << 16);
  end

  // ---------------------------------------------------------------------------
  // Speed root.
  // ---------------------------------------------------------------------------
  logic                    spd_vld;
  logic [SPD_ROOT_W-1:0]   spd_root;
  logic [2*DW:0]           spd_side;

  mpca_sqrt_pipe #(
    .RAD_W  (SPD_RAD_W),
    .SIDE_W (2 * DW + 1)
  ) u_speed_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_vld_q),
    .rad_i   (s3_rad_q),
    .side_i  ({s3_big_q, s3_dx_q, s3_dy_q}),
    .valid_o (spd_vld),
    .root_o  (spd_root),
    .side_o  (spd_side)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: threshold compare and excess speed. Stage 6: normalize by 100
  // (times 256, so divide the excess times 64 by 25). Stage 7: leading one and
  // mantissa in Q1.30.
  // ---------------------------------------------------------------------------
  logic        s5_vld_q, s6_vld_q;
  item_t       s5_item_q, s6_item_q;
  logic        s5_sat_q;
  logic [28:0] s5_x_q;
  logic [23:0] s6_n_q;
  logic [39:0] speed_w, thr_w, diff_w;
  logic [59:0] div_prod_w;
  logic [4:0]  msb_w;

  always_comb begin
    speed_w = spd_side[2*DW] ? {spd_root, 8'b0} : {8'b0, spd_root};
    thr_w   = {20'b0, speed_threshold_q, 8'b0};
    diff_w  = speed_w - thr_w;
  end

  assign div_prod_w = s5_x_q * DIV25_MAGIC;

  always_comb begin
    msb_w = '0;
    for (int b = 0; b < 24; b++) begin
      if (s6_n_q[b]) begin
        msb_w = 5'(b);
      end
    end
  end

  // Log stage arrays: index 0 is stage 7, index i is after i squarings.
  logic        lg_vld_q  [LOG_STEPS+1];
  item_t       lg_item_q [LOG_STEPS+1];
  logic [4:0]  lg_e_q    [LOG_STEPS+1];
  logic [30:0] lg_m_q    [LOG_STEPS+1];
  logic [15:0] lg_frac_q [LOG_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q    <= 1'b0;
      s6_vld_q    <= 1'b0;
      lg_vld_q[0] <= 1'b0;
    end else begin
      s5_vld_q    <= spd_vld;
      s6_vld_q    <= s5_vld_q;
      lg_vld_q[0] <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_item_q.dx     <= spd_side[2*DW-1:DW];
    s5_item_q.dy     <= spd_side[DW-1:0];
    s5_item_q.active <= accel_enable_q && (speed_w >= thr_w);
    s5_item_q.nz     <= 1'b0;
    s5_sat_q         <= diff_w >= N_SAT_DIFF;
    s5_x_q           <= {diff_w[22:0], 6'b0};

    s6_item_q.dx     <= s5_item_q.dx;
    s6_item_q.dy     <= s5_item_q.dy;
    s6_item_q.active <= s5_item_q.active;
    s6_item_q.nz     <= 1'b0;
    s6_n_q           <= s5_sat_q ? 24'hFF_FFFF : div_prod_w[58:35];

    lg_item_q[0].dx     <= s6_item_q.dx;
    lg_item_q[0].dy     <= s6_item_q.dy;
    lg_item_q[0].active <= s6_item_q.active;
    lg_item_q[0].nz     <= s6_n_q != 24'd0;
    lg_e_q[0]           <= msb_w;
    lg_m_q[0]           <= 31'({7'b0, s6_n_q} << (5'd30 - msb_w));
    lg_frac_q[0]        <= '0;
  end

  // ---------------------------------------------------------------------------
  // log2 fraction: square the mantissa once per stage, one result bit each.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
    logic [61:0] sq_w;
    logic [31:0] top_w;
    logic [30:0] m_d;
    logic [15:0] frac_d;

    always_comb begin
      sq_w   = lg_m_q[i] * lg_m_q[i];
      top_w  = sq_w[61:30];
      frac_d = lg_frac_q[i];
      if (top_w[31]) begin
        m_d                     = top_w[31:1];
        frac_d[LOG_STEPS-1-i]   = 1'b1;
      end else begin
        m_d = top_w[30:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lg_vld_q[i+1] <= 1'b0;
      end else begin
        lg_vld_q[i+1] <= lg_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      lg_item_q[i+1] <= lg_item_q[i];
      lg_e_q[i+1]    <= lg_e_q[i];
      lg_m_q[i+1]    <= m_d;
      lg_frac_q[i+1] <= frac_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: exponent product T = floor(power * log2 / 256) in Q.16.
  // ---------------------------------------------------------------------------
  logic               s8_vld_q;
  item_t              s8_item_q;
  logic signed [24:0] s8_t_q;
  logic signed [5:0]  ehi_w;
  logic signed [21:0] lg_w;
  logic signed [32:0] tp_w;

  always_comb begin
    ehi_w = $signed({1'b0, lg_e_q[LOG_STEPS]}) - 6'sd16;
    lg_w  = $signed({ehi_w, lg_frac_q[LOG_STEPS]});
    tp_w  = $signed({1'b0, curve_power_q}) * lg_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else begin
      s8_vld_q <= lg_vld_q[LOG_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    s8_item_q <= lg_item_q[LOG_STEPS];
    s8_t_q    <= tp_w[32:8];
  end

  // ---------------------------------------------------------------------------
  // exp2 fraction: for each exponent bit from the lsb, double if set, then
  // take the square root (in Q1.30).
  // ---------------------------------------------------------------------------
  logic                  exp_vld  [LOG_STEPS+1];
  logic [EXP_ROOT_W-1:0] exp_r    [LOG_STEPS+1];
  logic [EXP_SIDE_W-1:0] exp_side [LOG_STEPS+1];

  assign exp_vld[0]  = s8_vld_q;
  assign exp_r[0]    = EXP_ROOT_W'(31'h4000_0000);
  assign exp_side[0] = {s8_item_q, s8_t_q[24:16], s8_t_q[15:0]};

  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_exp
    exp_side_t        side_w;
    logic [31:0]      rin_w;
    logic [EXP_RAD_W-1:0] rad_w;

    always_comb begin
      side_w = exp_side_t'(exp_side[i]);
      rin_w  = side_w.f[i] ? {exp_r[i], 1'b0} : {1'b0, exp_r[i]};
      rad_w  = {rin_w, 30'b0};
    end

    mpca_sqrt_pipe #(
      .RAD_W  (EXP_RAD_W),
      .SIDE_W (EXP_SIDE_W)
    ) u_exp_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (exp_vld[i]),
      .rad_i   (rad_w),
      .side_i  (exp_side[i]),
      .valid_o (exp_vld[i+1]),
      .root_o  (exp_r[i+1]),
      .side_o  (exp_side[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 10: power term in Q.16. Stage 11: gain. Stage 12: scaled magnitudes.
  // Stage 13: sign and saturation into the output registers.
  // ---------------------------------------------------------------------------
  exp_side_t          fin_w;
  logic signed [9:0]  sh_w;
  logic [31:0]        pw_w;

  logic               s10_vld_q, s11_vld_q, s12_vld_q, s13_vld_q;
  item_t              s10_item_q, s11_item_q;
  logic [31:0]        s10_pw_q;
  logic [GAIN_W-1:0]  s11_gain_q, s12_gain_q;
  logic [40:0]        gm_w;
  logic [25:0]        gsum_w;
  logic [GAIN_W-1:0]  gain_w;
  logic [QW-1:0]      s12_qx_q, s12_qy_q;
  logic               s12_nx_q, s12_ny_q;
  logic [DW-1:0]      mx_w, my_w;
  logic [DW+GAIN_W-1:0] px_w, py_w;

  always_comb begin
    fin_w = exp_side_t'(exp_side[LOG_STEPS]);
    sh_w  = 10'sd14 - {fin_w.k[8], fin_w.k};
    if (!fin_w.item.nz) begin
      // Zero normalized speed: x^0 is one, any other power gives zero.
      pw_w = (curve_power_q == '0) ? 32'h0001_0000 : 32'h0;
    end else if (sh_w < 10'sd0) begin
      pw_w = 32'h4000_0000;
    end else if (sh_w >= 10'sd63) begin
      pw_w = 32'h0;
    end else begin
      pw_w = 32'({1'b0, exp_r[LOG_STEPS]} >> sh_w[5:0]);
    end
  end

  always_comb begin
    gm_w   = s10_pw_q * accel_factor_q;
    gsum_w = 26'(gm_w[40:16]) + 26'(GAIN_UNITY);
    if (!s10_item_q.active) begin
      gain_w = GAIN_UNITY;
    end else if (gsum_w > 26'(GAIN_MAX)) begin
      gain_w = GAIN_MAX;
    end else if (gsum_w < 26'(GAIN_MIN)) begin
      gain_w = GAIN_MIN;
    end else begin
      gain_w = gsum_w[GAIN_W-1:0];
    end
  end

  always_comb begin
    mx_w = s11_item_q.dx[DW-1] ? DW'(-s11_item_q.dx) : DW'(s11_item_q.dx);
    my_w = s11_item_q.dy[DW-1] ? DW'(-s11_item_q.dy) : DW'(s11_item_q.dy);
    px_w = mx_w * s11_gain_q;
    py_w = my_w * s11_gain_q;
  end

  // Truncation toward zero happens on the magnitude; the sign comes back last.
  function automatic logic [DW-1:0] sat_out(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] lim;
    logic [DW-1:0] res;
    lim = QW'(1) << (DW - 1);
    if (neg) begin
      res = (q > lim) ? {1'b1, {(DW-1){1'b0}}} : DW'(-q[DW-1:0]);
    end else begin
      res = (q >= lim) ? {1'b0, {(DW-1){1'b1}}} : q[DW-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
      s12_vld_q <= 1'b0;
      s13_vld_q <= 1'b0;
    end else begin
      s10_vld_q <= exp_vld[LOG_STEPS];
      s11_vld_q <= s10_vld_q;
      s12_vld_q <= s11_vld_q;
      s13_vld_q <= s12_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s10_item_q  <= fin_w.item;
    s10_pw_q    <= pw_w;
    s11_item_q  <= s10_item_q;
    s11_gain_q  <= gain_w;
    s12_qx_q    <= QW'(px_w >> 8);
    s12_qy_q    <= QW'(py_w >> 8);
    s12_nx_q    <= s11_item_q.dx[DW-1];
    s12_ny_q    <= s11_item_q.dy[DW-1];
    s12_gain_q  <= s11_gain_q;
    scaled_x_o  <= sat_out(s12_qx_q, s12_nx_q);
    scaled_y_o  <= sat_out(s12_qy_q, s12_ny_q);
    gain_used_o <= s12_gain_q;
  end

  assign result_valid_o = s13_vld_q;

  `MPCA_ASSERT_DLY(a_item_latency, clk_i, rst_ni, start && !busy, LAT, result_valid_o)
  `MPCA_ASSERT_IMP(a_gain_range, clk_i, rst_ni, result_valid_o, (gain_used_o >= GAIN_MIN) && (gain_used_o <= GAIN_MAX))

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mpca_pkg::*;

  localparam int DW = 16;
  // Leave the watchdog ample room for a report to pass the whole pipeline.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic [GAIN_W-1:0]    g;
  } report_t;

  // One row of the directed part: either a register write or a report.
  typedef struct {
    bit          is_cfg;
    cfg_reg_e    reg_sel;
    int unsigned value;
    int          dx;
    int          dy;
    bit          typed;
    report_t     want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [DW-1:0] delta_x_i = '0;
  logic signed [DW-1:0] delta_y_i = '0;
  logic result_valid_o;
  logic signed [DW-1:0] scaled_x_o;
  logic signed [DW-1:0] scaled_y_o;
  logic [GAIN_W-1:0] gain_used_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // Shadow copy of the configuration, used by the gain predictor.
  logic [FACTOR_W-1:0] cur_factor;
  logic [POWER_W-1:0]  cur_power;
  logic [THR_W-1:0]    cur_thr;
  logic                cur_enable;

  report_t pending_reports[$];
  int error_count = 0;
  int quiet_cycles = 0;
  row_t rows[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mouse_power_curve_accel #(.DELTA_WIDTH(DW)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .delta_x_i(delta_x_i), .delta_y_i(delta_y_i),
    .result_valid_o(result_valid_o), .scaled_x_o(scaled_x_o),
    .scaled_y_o(scaled_y_o), .gain_used_o(gain_used_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Bit-serial integer square root, floor of the exact root.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Normalized speed n (Q8.16, nonzero) raised to exponent p (Q2.8), result in Q.16.
  // The log2 comes from repeated squaring of the mantissa, the exp2 fraction
  // from a chain of square roots, one per fraction bit.
  function automatic longint unsigned curve_term(longint unsigned n, longint unsigned p);
    int e;
    longint unsigned m;
    longint unsigned frac;
    longint unsigned r;
    longint lg;
    longint t;
    longint k;
    longint f;
    longint sh;
    e = 0;
    frac = 0;
    while (e < 63 && (n >> (e + 1)) != 0) e++;
    m = (e <= 30) ? (n << (30 - e)) : (n >> (e - 30));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (15 - i));
      end
    end
    lg = longint'(e - 16) * 65536 + longint'(frac);
    // Arithmetic right shifts of a signed value floor toward minus infinity.
    t = (longint'(p) * lg) >>> 8;
    k = t >>> 16;
    f = t - k * 65536;
    r = 64'd1 << 30;
    for (int i = 0; i < 16; i++) begin
      if ((f >> i) & 1) r = r << 1;
      r = int_sqrt(r << 30);
    end
    sh = 14 - k;
    if (sh >= 63) return 0;
    if (sh < 0) return 64'd1 << 30;
    return r >> sh;
  endfunction

  // Delta times gain, truncated toward zero and saturated to the delta range.
  function automatic logic signed [DW-1:0] apply_gain(longint d, longint unsigned g);
    longint unsigned mag;
    longint q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = longint'((mag * g) >> 8);
    if (d < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[DW-1:0];
  endfunction

  function automatic report_t predict_report(logic signed [DW-1:0] dx,
                                             logic signed [DW-1:0] dy);
    report_t res;
    longint sx;
    longint sy;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned sum;
    longint unsigned speed;
    longint unsigned thr;
    longint unsigned n;
    longint unsigned pw;
    longint unsigned gain;
    sx = dx;
    sy = dy;
    gain = 256;
    if (cur_enable) begin
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      sum = ax * ax + ay * ay;
      // Very large movements take the coarse speed form.
      speed = (sum < (64'd1 << 47)) ? int_sqrt(sum << 16) : (int_sqrt(sum) << 8);
      thr = longint'(cur_thr) << 8;
      if (speed >= thr) begin
        n = ((speed - thr) << 8) / 100;
        if (n > 64'hFF_FFFF) n = 64'hFF_FFFF;
        // At exactly the threshold the power term is zero, unless the
        // exponent is zero, in which case it is one.
        if (n == 0) pw = (cur_power == 0) ? 65536 : 0;
        else pw = curve_term(n, cur_power);
        gain = 256 + ((longint'(cur_factor) * pw) >> 16);
        if (gain > 768) gain = 768;
        if (gain < 128) gain = 128;
      end
    end
    res.x = apply_gain(sx, gain);
    res.y = apply_gain(sy, gain);
    res.g = gain[GAIN_W-1:0];
    return res;
  endfunction

  // Compare every report against the oldest prediction.
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report x=%0d y=%0d gain=%0d", $time,
                 scaled_x_o, scaled_y_o, gain_used_o);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (scaled_x_o !== want.x) begin
          $display("%0t: scaled_x expected %0d, got %0d", $time, want.x, scaled_x_o);
          error_count++;
        end
        if (scaled_y_o !== want.y) begin
          $display("%0t: scaled_y expected %0d, got %0d", $time, want.y, scaled_y_o);
          error_count++;
        end
        if (gain_used_o !== want.g) begin
          $display("%0t: gain_used expected %0d, got %0d", $time, want.g, gain_used_o);
          error_count++;
        end
      end
    end
  end

  // The watchdog counts cycles in which no item and no report moved.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Write one register and read it back; the write lands at the access edge.
  task automatic write_reg(cfg_reg_e sel, int unsigned value);
    logic [DATA_W-1:0] mask;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    case (sel)
      REG_ACCEL_FACTOR:    begin cur_factor = value; mask = (1 << FACTOR_W) - 1; end
      REG_CURVE_POWER:     begin cur_power = value;  mask = (1 << POWER_W) - 1;  end
      REG_SPEED_THRESHOLD: begin cur_thr = value;    mask = (1 << THR_W) - 1;    end
      default:             begin cur_enable = value; mask = 1;                   end
    endcase
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (value & mask)) begin
      $display("%0t: register %s read expected %0d, got %0d", $time, sel.name(),
               value & mask, prdata & mask);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold a report on the inputs until it is taken, after an optional gap.
  task automatic send_report(int dx, int dy, int idle_pct, bit typed, report_t want);
    report_t pred;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    delta_x_i <= dx;
    delta_y_i <= dy;
    do @(posedge clk_i); while (busy);
    pred = predict_report(dx[DW-1:0], dy[DW-1:0]);
    pending_reports.push_back(typed ? want : pred);
  endtask

  // Configuration changes only while nothing is in flight.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  function automatic row_t item_row(int dx, int dy, bit typed, int wx, int wy, int wg);
    row_t r;
    r.is_cfg = 1'b0;
    r.reg_sel = REG_ACCEL_FACTOR;
    r.value = 0;
    r.dx = dx;
    r.dy = dy;
    r.typed = typed;
    r.want.x = wx;
    r.want.y = wy;
    r.want.g = wg;
    return r;
  endfunction

  function automatic row_t cfg_row(cfg_reg_e sel, int unsigned value);
    row_t r;
    r = item_row(0, 0, 1'b0, 0, 0, 0);
    r.is_cfg = 1'b1;
    r.reg_sel = sel;
    r.value = value;
    return r;
  endfunction

  function automatic int random_delta(int thr);
    int lim;
    case ($urandom_range(3))
      0: return $signed($urandom_range(16'hFFFF, 0) ^ 32'h0) - 32768;
      3: case ($urandom_range(3))
           0: return -32768;
           1: return 32767;
           2: return 0;
           default: return -1;
         endcase
      default: begin
        // Keep most movements near the knee of the curve.
        lim = thr + 2000;
        return int'($urandom_range(2 * lim)) - lim;
      end
    endcase
  endfunction

  int unsigned phase_cfg[6][4] = '{
    '{154, 512,   50, 1},
    '{  0, 384,    0, 1},
    '{256, 768, 4095, 1},
    '{511, 1023, 100, 1},
    '{200,   0,   20, 1},
    '{154, 600,  300, 0}
  };
  int phase_idle[6] = '{24, 24, 75, 75, 0, 0};

  initial begin
    row_t r;
    cur_factor = FACTOR_RST;
    cur_power = POWER_RST;
    cur_thr = THR_RST;
    cur_enable = 1'b1;

    // Directed part: extremes, threshold edges, zero exponent, pass-through.
    rows.push_back(item_row(0, 0, 1, 0, 0, 256));
    rows.push_back(item_row(10, -7, 1, 10, -7, 256));
    rows.push_back(item_row(32767, 32767, 1, 32767, 32767, 768));
    rows.push_back(item_row(-32768, -32768, 1, -32768, -32768, 768));
    rows.push_back(item_row(-32768, 0, 1, -32768, 0, 768));
    rows.push_back(item_row(100, 0, 0, 0, 0, 0));
    rows.push_back(item_row(0, -200, 0, 0, 0, 0));
    rows.push_back(item_row(-300, 400, 0, 0, 0, 0));
    rows.push_back(item_row(60, 80, 0, 0, 0, 0));
    rows.push_back(item_row(1000, -1000, 0, 0, 0, 0));
    rows.push_back(item_row(50, 0, 0, 0, 0, 0));
    rows.push_back(cfg_row(REG_CURVE_POWER, 0));
    rows.push_back(cfg_row(REG_ACCEL_FACTOR, 256));
    rows.push_back(item_row(50, 0, 1, 100, 0, 512));
    rows.push_back(item_row(0, -50, 1, 0, -100, 512));
    rows.push_back(item_row(700, 30, 0, 0, 0, 0));
    rows.push_back(cfg_row(REG_ACCEL_ENABLE, 0));
    rows.push_back(item_row(-32768, 32767, 1, -32768, 32767, 256));
    rows.push_back(item_row(1234, -1234, 1, 1234, -1234, 256));
    rows.push_back(cfg_row(REG_ACCEL_ENABLE, 1));
    rows.push_back(cfg_row(REG_ACCEL_FACTOR, 0));
    rows.push_back(item_row(5000, 5000, 1, 5000, 5000, 256));
    rows.push_back(cfg_row(REG_SPEED_THRESHOLD, 4095));
    rows.push_back(item_row(-4000, 900, 1, -4000, 900, 256));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.is_cfg) begin
        wait_idle();
        write_reg(r.reg_sel, r.value);
      end else begin
        send_report(r.dx, r.dy, 0, r.typed, r.want);
      end
    end

    // Random part, in phases of different settings and gap rates.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_reg(REG_ACCEL_FACTOR, phase_cfg[p][0]);
      write_reg(REG_CURVE_POWER, phase_cfg[p][1]);
      write_reg(REG_SPEED_THRESHOLD, phase_cfg[p][2]);
      write_reg(REG_ACCEL_ENABLE, phase_cfg[p][3]);
      for (int i = 0; i < 100; i++) begin
        send_report(random_delta(cur_thr), random_delta(cur_thr), phase_idle[p], 1'b0,
                    '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
